[sv/rcfp_pkg.sv]
// Shared constants and types for the RC channel frame parser.
// Used by the front end, job queue, back end and top level; no dependencies.
`default_nettype none

package rcfp_pkg;

   localparam int unsigned NUM_CHANNELS_DEF = 12;
   localparam int unsigned CH_W             = 4;
   localparam int unsigned RAW_W            = 11;
   localparam int unsigned US_W             = 11;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned CNT_W            = 6;
   localparam int unsigned PAYLOAD_BYTES    = 17;
   localparam int unsigned PAYLOAD_W        = PAYLOAD_BYTES * BYTE_W;
   localparam int unsigned PAY_IDX_W        = 5;
   localparam int unsigned BIT_BASE_W       = 8;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hC8;
   localparam logic [BYTE_W-1:0] TYPE_RC   = 8'h16;
   localparam logic [BYTE_W-1:0] LEN_MIN   = 8'd2;
   localparam logic [BYTE_W-1:0] LEN_MAX   = 8'd62;
   localparam logic [BYTE_W-1:0] LEN_FULL  = 8'd18;
   localparam logic [CNT_W-1:0]  POS_MAX   = 6'd63;
   localparam logic [CNT_W-1:0]  POS_LAST_PAYLOAD = 6'd17;

   localparam logic [RAW_W-1:0] RAW_MIN = 11'd172;
   localparam logic [RAW_W-1:0] RAW_MAX = 11'd1811;
   localparam logic [US_W-1:0]  US_BASE = 11'd1000;
   // floor(d * 1000 / 1639) == (d * US_SCALE_MUL) >> 32 for d in 0..1639
   localparam logic [31:0]      US_SCALE_MUL = 32'd2620481000;

   typedef struct packed {
      logic                 push;
      logic [PAYLOAD_W-1:0] payload;
   } job_type;

endpackage

`default_nettype wire

[sv/rcfp_front.sv]
// Front end: byte-level frame parser that collects the payload and queues decode jobs.
// Depends on rcfp_pkg.
`default_nettype none

module rcfp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [rcfp_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic                          rx_error,
   output wire rcfp_pkg::job_type             job
);

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [rcfp_pkg::CNT_W-1:0]             left_ff, left_in;
   logic [rcfp_pkg::CNT_W-1:0]             pos_ff, pos_in;
   logic                                   type_ff, type_in;
   logic                                   long_ff, long_in;
   logic [rcfp_pkg::PAYLOAD_W-1:0]         store_ff, store_in;
   logic [rcfp_pkg::PAY_IDX_W-1:0]         wr_idx;
   logic                                   push;

   assign wr_idx = rcfp_pkg::PAY_IDX_W'(pos_ff - 6'd1);

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      pos_in   = pos_ff;
      type_in  = type_ff;
      long_in  = long_ff;
      store_in = store_ff;
      push     = 1'b0;
      if (rx_error) begin
         phase_in = PH_SYNC;
      end else begin
         unique case (phase_ff)
            PH_LEN: begin
               if (rx_byte >= rcfp_pkg::LEN_MIN && rx_byte <= rcfp_pkg::LEN_MAX) begin
                  left_in  = rcfp_pkg::CNT_W'(rx_byte);
                  pos_in   = '0;
                  type_in  = 1'b0;
                  long_in  = (rx_byte >= rcfp_pkg::LEN_FULL);
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_SYNC;
               end
            end
            PH_BODY: begin
               if (pos_ff == '0) begin
                  type_in = (rx_byte == rcfp_pkg::TYPE_RC);
               end else if (pos_ff <= rcfp_pkg::POS_LAST_PAYLOAD) begin
                  store_in[{wr_idx, 3'b000} +: rcfp_pkg::BYTE_W] = rx_byte;
               end
               if (pos_ff < rcfp_pkg::POS_MAX) begin
                  pos_in = pos_ff + 6'd1;
               end
               if (left_ff != '0) begin
                  left_in = left_ff - 6'd1;
               end
               if (left_in == '0) begin
                  phase_in = PH_SYNC;
                  push     = type_ff & long_ff;
               end
            end
            default: begin
               phase_in = (rx_byte == rcfp_pkg::SYNC_BYTE) ? PH_LEN : PH_SYNC;
            end
         endcase
      end
   end

   assign job.push    = accept & push;
   assign job.payload = store_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC;
         left_ff  <= '0;
         pos_ff   <= '0;
         type_ff  <= 1'b0;
         long_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         long_ff  <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

endmodule

`default_nettype wire

[sv/rcfp_queue.sv]
// Two-entry job queue between the parser front end and the channel back end.
// Depends on rcfp_pkg.
`default_nettype none

module rcfp_queue (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rcfp_pkg::job_type                job,
   input  wire logic                             pop,
   output logic                                  full,
   output logic                                  not_empty,
   output logic [rcfp_pkg::PAYLOAD_W-1:0]        head
);

   logic [rcfp_pkg::PAYLOAD_W-1:0] entries_ff [2];
   logic                           wr_ptr_ff, wr_ptr_in;
   logic                           rd_ptr_ff, rd_ptr_in;
   logic [1:0]                     count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ job.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(job.push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job.push) begin
         entries_ff[wr_ptr_ff] <= job.payload;
      end
   end

endmodule

`default_nettype wire

[sv/rcfp_back.sv]
// Back end: walks the channels of a queued payload, unpacks, clamps and scales each.
// Depends on rcfp_pkg.
`default_nettype none

module rcfp_back #(
   parameter int unsigned NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            job_ready,
   input  wire logic [rcfp_pkg::PAYLOAD_W-1:0]  payload,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [rcfp_pkg::CH_W-1:0]            rsp_channel_index,
   output logic [rcfp_pkg::RAW_W-1:0]           rsp_raw_value,
   output logic [rcfp_pkg::US_W-1:0]            rsp_pulse_us,
   output logic                                 rsp_last
);

   localparam logic [rcfp_pkg::CH_W-1:0] LAST_CH = rcfp_pkg::CH_W'(NUM_CHANNELS - 1);

   logic [rcfp_pkg::CH_W-1:0]        ch_ff, ch_in;
   logic                             s1_valid_ff;
   logic [rcfp_pkg::CH_W-1:0]        s1_ch_ff;
   logic [rcfp_pkg::RAW_W-1:0]       s1_raw_ff;
   logic [rcfp_pkg::RAW_W-1:0]       s1_diff_ff;
   logic                             out_valid_ff;
   logic [rcfp_pkg::CH_W-1:0]        out_ch_ff;
   logic [rcfp_pkg::RAW_W-1:0]       out_raw_ff;
   logic [rcfp_pkg::US_W-1:0]        out_us_ff, out_us_in;
   logic                             out_last_ff;

   logic                             out_load;
   logic                             s1_load;
   logic                             issue;
   logic [rcfp_pkg::BIT_BASE_W-1:0]  bit_base;
   logic [rcfp_pkg::RAW_W-1:0]       raw;
   logic [rcfp_pkg::RAW_W-1:0]       clamped;
   logic [rcfp_pkg::RAW_W+31:0]      product;

   assign out_load = ~out_valid_ff | ~rsp_stall;
   assign s1_load  = ~s1_valid_ff | out_load;
   assign issue    = s1_load & job_ready;
   assign pop      = issue & (ch_ff == LAST_CH);
   assign ch_in    = pop ? '0 : (ch_ff + 4'd1);

   assign bit_base = rcfp_pkg::BIT_BASE_W'(ch_ff) * 8'd11;
   assign raw      = payload[bit_base +: rcfp_pkg::RAW_W];

   always_comb begin
      clamped = raw;
      if (raw < rcfp_pkg::RAW_MIN) begin
         clamped = rcfp_pkg::RAW_MIN;
      end else if (raw > rcfp_pkg::RAW_MAX) begin
         clamped = rcfp_pkg::RAW_MAX;
      end
   end

   assign product   = (rcfp_pkg::RAW_W + 32)'(s1_diff_ff)
                      * (rcfp_pkg::RAW_W + 32)'(rcfp_pkg::US_SCALE_MUL);
   assign out_us_in = rcfp_pkg::US_BASE + product[rcfp_pkg::RAW_W+31:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            ch_ff <= ch_in;
         end
         if (s1_load) begin
            s1_valid_ff <= issue;
         end
         if (out_load) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ch_ff   <= ch_ff;
         s1_raw_ff  <= raw;
         s1_diff_ff <= clamped - rcfp_pkg::RAW_MIN;
      end
      if (out_load && s1_valid_ff) begin
         out_ch_ff   <= s1_ch_ff;
         out_raw_ff  <= s1_raw_ff;
         out_us_ff   <= out_us_in;
         out_last_ff <= (s1_ch_ff == LAST_CH);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_ch_ff;
   assign rsp_raw_value     = out_raw_ff;
   assign rsp_pulse_us      = out_us_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

[sv/rc_channel_frame_parser_unit.sv]
// Top level: one received byte per transfer, accepted every cycle while the job queue has room.
// A frame-end byte of a valid RC frame queues a job; its results pass the queue entry, the s1
// and output registers; NUM_CHANNELS results follow, one per cycle while rsp_stall is low.
// Up to two decoded frames wait in the queue before req_stall rises.
// Synchronous active-high reset returns the parser to sync hunt and empties queue and outputs.
// Depends on rcfp_pkg, rcfp_front, rcfp_queue, rcfp_back.
`default_nettype none

module rc_channel_frame_parser_unit #(
   parameter int unsigned NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rcfp_pkg::BYTE_W-1:0]   req_rx_byte,
   input  wire logic                          req_rx_error,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rcfp_pkg::CH_W-1:0]          rsp_channel_index,
   output logic [rcfp_pkg::RAW_W-1:0]         rsp_raw_value,
   output logic [rcfp_pkg::US_W-1:0]          rsp_pulse_us,
   output logic                               rsp_last
);

   rcfp_pkg::job_type                 job;
   logic                              accept;
   logic                              q_full;
   logic                              q_not_empty;
   logic                              q_pop;
   logic [rcfp_pkg::PAYLOAD_W-1:0]    q_head;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   rcfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .rx_error (req_rx_error),
      .job      (job)
   );

   rcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rcfp_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_ready         (q_not_empty),
      .payload           (q_head),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_pulse_us      (rsp_pulse_us),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire
